/* src/mcma_pkg.sv */
// ----------------------------------------------------------------------------
// mcma_pkg
// Shared constants, widths and types of the multichannel moving average unit.
// ----------------------------------------------------------------------------
package mcma_pkg;

   // block dimensions
   localparam int CHANNELS  = 8;
   localparam int WINDOW    = 16;

   // field widths
   localparam int CHANNEL_W = 3;
   localparam int SAMPLE_W  = 12;
   localparam int TDATA_W   = ((CHANNEL_W + SAMPLE_W + 7) / 8) * 8;

   // derived widths
   localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int POS_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int FILL_W    = $clog2(WINDOW + 1);
   localparam int SUM_W     = $clog2(WINDOW * ((1 << SAMPLE_W) - 1) + 1);
   localparam int RING_DEPTH = CHANNELS * WINDOW;
   localparam int ADDR_W    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int CNT_W     = (SUM_W > 1) ? $clog2(SUM_W) : 1;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_DIVIDE,
      ST_OUTPUT
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic load_in;   // latch request, start ring read
      logic update;    // update channel state, start divider
      logic div_step;  // one quotient bit
      logic out_load;  // load result register
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic invalid;   // channel beyond the configured count
      logic div_last;  // last quotient bit this cycle
      logic out_busy;  // result register cannot take a new result
   } status_type;

endpackage

/* src/mcma_ram.sv */
// ----------------------------------------------------------------------------
// mcma_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mcma_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 128
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/mcma_datapath.sv */
// ----------------------------------------------------------------------------
// mcma_datapath
// Per-channel sums, fill counts and positions, the sample ring, a restoring
// divider and the result register.
// ----------------------------------------------------------------------------
module mcma_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  mcma_pkg::cmd_type                   cmd,
   output mcma_pkg::status_type                status,
   input  logic [mcma_pkg::CHANNEL_W-1:0]      req_channel,
   input  logic [mcma_pkg::SAMPLE_W-1:0]       req_sample,
   input  logic                                rsp_tready,
   output logic                                rsp_valid,
   output logic [mcma_pkg::CHANNEL_W-1:0]      rsp_channel,
   output logic [mcma_pkg::SAMPLE_W-1:0]       rsp_average
);
   import mcma_pkg::*;

   localparam int CHX_W = CH_IDX_W + CHANNEL_W;

   // per-channel state
   logic [SUM_W-1:0]     sum_ff  [CHANNELS];
   logic [FILL_W-1:0]    fill_ff [CHANNELS];
   logic [POS_W-1:0]     pos_ff  [CHANNELS];

   // latched request
   logic [CHANNEL_W-1:0] ch_ff;
   logic [SAMPLE_W-1:0]  sample_ff;
   logic [CH_IDX_W-1:0]  idx_ff;
   logic [ADDR_W-1:0]    addr_ff;
   logic                 invalid_ff;

   // divider
   logic [FILL_W-1:0]    rem_ff,  rem_in;
   logic [SUM_W-1:0]     quo_ff,  quo_in;
   logic [FILL_W-1:0]    dvs_ff;
   logic [CNT_W-1:0]     cnt_ff;

   // result register
   logic                 out_valid_ff;
   logic [CHANNEL_W-1:0] out_channel_ff;
   logic [SAMPLE_W-1:0]  out_average_ff;

   // request decode
   logic [CHX_W-1:0]     ch_ext;
   logic [CH_IDX_W-1:0]  req_idx;
   logic                 req_invalid;
   logic [ADDR_W-1:0]    req_addr;

   // update path
   logic [SAMPLE_W-1:0]  old_sample;
   logic                 full;
   logic [SUM_W-1:0]     sum_in;
   logic [FILL_W-1:0]    fill_in;
   logic [POS_W-1:0]     pos_in;

   // divider step
   logic [FILL_W:0]      shifted;
   logic [FILL_W:0]      diff;
   logic                 q_bit;

   // channel index and ring address of the incoming request
   always_comb begin
      ch_ext      = CHX_W'(req_channel);
      req_idx     = ch_ext[CH_IDX_W-1:0];
      req_invalid = (ch_ext >= CHX_W'(CHANNELS));
      req_addr    = ADDR_W'(req_idx) * ADDR_W'(WINDOW) + ADDR_W'(pos_ff[req_idx]);
   end

   // latch the request
   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         ch_ff      <= req_channel;
         sample_ff  <= req_sample;
         idx_ff     <= req_idx;
         addr_ff    <= req_addr;
         invalid_ff <= req_invalid;
      end
   end

   // sample ring, read on accept, written back during update
   mcma_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (cmd.update && !invalid_ff),
      .wr_addr (addr_ff),
      .wr_data (sample_ff),
      .rd_en   (cmd.load_in),
      .rd_addr (req_addr),
      .rd_data (old_sample)
   );

   // new sum, fill count and position for the channel
   always_comb begin
      full    = (fill_ff[idx_ff] == FILL_W'(WINDOW));
      sum_in  = sum_ff[idx_ff] - (full ? SUM_W'(old_sample) : '0) + SUM_W'(sample_ff);
      fill_in = full ? fill_ff[idx_ff] : fill_ff[idx_ff] + 1'b1;
      pos_in  = (pos_ff[idx_ff] == POS_W'(WINDOW - 1)) ? '0 : pos_ff[idx_ff] + 1'b1;
   end

   // per-channel state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            sum_ff[i]  <= '0;
            fill_ff[i] <= '0;
            pos_ff[i]  <= '0;
         end
      end else if (cmd.update && !invalid_ff) begin
         sum_ff[idx_ff]  <= sum_in;
         fill_ff[idx_ff] <= fill_in;
         pos_ff[idx_ff]  <= pos_in;
      end
   end

   // restoring divider step
   always_comb begin
      shifted = {rem_ff, quo_ff[SUM_W-1]};
      diff    = shifted - {1'b0, dvs_ff};
      q_bit   = (shifted >= {1'b0, dvs_ff});
      rem_in  = q_bit ? diff[FILL_W-1:0] : shifted[FILL_W-1:0];
      quo_in  = {quo_ff[SUM_W-2:0], q_bit};
   end

   // divider registers, one quotient bit per cycle
   always_ff @(posedge clock) begin
      if (cmd.update) begin
         rem_ff <= '0;
         quo_ff <= sum_in;
         dvs_ff <= fill_in;
         cnt_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_channel_ff <= ch_ff;
         out_average_ff <= invalid_ff ? '0 : quo_ff[SAMPLE_W-1:0];
      end
   end

   // status and outputs
   assign status.invalid  = invalid_ff;
   assign status.div_last = (cnt_ff == CNT_W'(SUM_W - 1));
   assign status.out_busy = out_valid_ff && !rsp_tready;

   assign rsp_valid   = out_valid_ff;
   assign rsp_channel = out_channel_ff;
   assign rsp_average = out_average_ff;

endmodule

/* src/mcma_ctrl.sv */
// ----------------------------------------------------------------------------
// mcma_ctrl
// Sequencer: accept, update, divide, hand over the result.
// ----------------------------------------------------------------------------
module mcma_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  mcma_pkg::status_type status,
   output mcma_pkg::cmd_type    cmd
);
   import mcma_pkg::*;

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_in = 1'b1;
               state_in    = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = status.invalid ? ST_OUTPUT : ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_OUTPUT;
            end
         end
         ST_OUTPUT: begin
            if (!status.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* src/multichannel_moving_average_unit.sv */
// ----------------------------------------------------------------------------
// multichannel_moving_average_unit
// Per-channel moving average of tagged ADC samples over a ring of the last
// samples; the result is the running sum divided by the fill count.
//
//   channel | dir | payload (tdata, low bit up)
//   --------+-----+-------------------------------------------
//   req_    | in  | channel[2:0], sample[14:3], zero pad
//   rsp_    | out | out_channel[2:0], average[14:3], zero pad
//
// one request runs from its accept through an update state, the
// restoring divider at one quotient bit per cycle and an output load,
// and only then is the next request accepted.
// reset clears the sums, fill counts and positions; ring entries are
// read on every accept but used only after they were written.
// the result register holds one finished result; while it stalls, the
// next request is accepted and runs up to its own output load.
// ----------------------------------------------------------------------------
module multichannel_moving_average_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [mcma_pkg::TDATA_W-1:0]  req_tdata,   // channel, sample
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [mcma_pkg::TDATA_W-1:0]  rsp_tdata    // out_channel, average
);
   import mcma_pkg::*;

   cmd_type              cmd;
   status_type           status;
   logic [CHANNEL_W-1:0] rsp_channel;
   logic [SAMPLE_W-1:0]  rsp_average;

   // sequencer
   mcma_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // datapath
   mcma_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_channel (req_tdata[CHANNEL_W-1:0]),
      .req_sample  (req_tdata[CHANNEL_W+SAMPLE_W-1:CHANNEL_W]),
      .rsp_tready  (rsp_tready),
      .rsp_valid   (rsp_tvalid),
      .rsp_channel (rsp_channel),
      .rsp_average (rsp_average)
   );

   // pack the result
   assign rsp_tdata = TDATA_W'({rsp_average, rsp_channel});

endmodule

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the multichannel moving average unit. Tagged
// samples go in on the request stream. A per-channel model of the ring,
// running sum, fill count and write slot predicts each average. Every
// response is compared field by field in arrival order. Traffic runs
// through phases of sender gaps and receiver back-pressure.
// ----------------------------------------------------------------------------
module tb;

   import mcma_pkg::*;

   localparam int CLOCK_HALF   = 5;
   localparam int RESET_CYCLES = 12;
   localparam int BLOCK_CYCLES = SUM_W + 3;
   localparam int SETTLE       = 4 * BLOCK_CYCLES;
   localparam int STALL_LIMIT  = 5000;
   localparam int CHANNEL_MAX  = (1 << CHANNEL_W) - 1;
   localparam int SAMPLE_MAX   = (1 << SAMPLE_W) - 1;

   typedef struct packed {
      logic [CHANNEL_W-1:0] channel;
      logic [SAMPLE_W-1:0]  average;
   } average_result_type;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [TDATA_W-1:0]  req_tdata;   // channel, sample
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [TDATA_W-1:0]  rsp_tdata;   // out_channel, average

   // per-channel averaging state
   logic [SAMPLE_W-1:0] history      [CHANNELS][WINDOW];
   logic [SUM_W-1:0]    channel_sum  [CHANNELS];
   logic [FILL_W-1:0]   channel_fill [CHANNELS];
   logic [POS_W-1:0]    channel_slot [CHANNELS];

   average_result_type pending_averages[$];
   int                 fail_count = 0;
   int                 send_idle_pct;
   int                 recv_stall_pct;
   int                 quiet_cycles;

   multichannel_moving_average_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // clock generation
   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   // mean of the held samples after taking one new sample
   function automatic average_result_type predict_average(input logic [CHANNEL_W-1:0] ch,
                                                          input logic [SAMPLE_W-1:0] smp);
      average_result_type res;
      int                 slot;
      int                 sum;
      res.channel = ch;
      res.average = '0;
      // channel outside the configured count leaves state untouched
      if (int'(ch) >= CHANNELS) return res;
      slot = int'(channel_slot[ch]);
      if (slot >= WINDOW) slot = 0;
      sum = int'(channel_sum[ch]);
      // full ring drops its oldest sample, otherwise it grows by one
      if (int'(channel_fill[ch]) >= WINDOW) sum -= int'(history[ch][slot]);
      else channel_fill[ch] = channel_fill[ch] + 1'b1;
      history[ch][slot] = smp;
      sum += int'(smp);
      channel_sum[ch] = sum[SUM_W-1:0];
      slot = (slot + 1 >= WINDOW) ? 0 : slot + 1;
      channel_slot[ch] = slot[POS_W-1:0];
      res.average = SAMPLE_W'(sum / int'(channel_fill[ch]));
      return res;
   endfunction

   // one request, with random gaps ahead of it in idle phases
   task automatic send_sample(input logic [CHANNEL_W-1:0] ch, input logic [SAMPLE_W-1:0] smp);
      logic [TDATA_W-1:0] word;
      word = '0;
      word[CHANNEL_W-1:0] = ch;
      word[CHANNEL_W +: SAMPLE_W] = smp;
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      do @(posedge clock); while (!req_tready);
      pending_averages.push_back(predict_average(ch, smp));
   endtask

   // drop valid and hold until every response is back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_averages.size() != 0);
   endtask

   // random samples, biased to zero and full scale, with the odd same-channel burst
   task automatic random_samples(input int count);
      int                   sent;
      int                   pick;
      logic [CHANNEL_W-1:0] ch;
      logic [SAMPLE_W-1:0]  smp;
      sent = 0;
      while (sent < count) begin
         ch = CHANNEL_W'($urandom_range(CHANNEL_MAX));
         if ($urandom_range(39) == 0) begin
            // burst of one level on one channel to reach extreme sums
            smp = $urandom_range(1) ? SAMPLE_W'(SAMPLE_MAX) : '0;
            repeat (WINDOW + 4) send_sample(ch, smp);
            sent += WINDOW + 4;
         end else begin
            pick = $urandom_range(7);
            if (pick == 0) smp = '0;
            else if (pick == 1) smp = SAMPLE_W'(SAMPLE_MAX);
            else smp = SAMPLE_W'($urandom_range(SAMPLE_MAX));
            send_sample(ch, smp);
            sent++;
         end
      end
   endtask

   // field extremes, truncation, warm-up and ring wrap at full scale
   task automatic test_directed();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      send_sample(CHANNEL_W'(CHANNEL_MAX), '0);
      send_sample(CHANNEL_W'(CHANNEL_MAX), SAMPLE_W'(SAMPLE_MAX));
      send_sample(CHANNEL_W'(3), SAMPLE_W'(1));
      send_sample(CHANNEL_W'(3), SAMPLE_W'(2));
      repeat (WINDOW + 1) send_sample('0, SAMPLE_W'(SAMPLE_MAX));
      send_sample('0, '0);
      send_sample(CHANNEL_W'(5), SAMPLE_W'(12'haaa));
      send_sample(CHANNEL_W'(2), SAMPLE_W'(12'h555));
      wait_drained();
   endtask

   task automatic test_back_to_back();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      random_samples(400);
   endtask

   task automatic test_sender_gaps();
      send_idle_pct  = 85;
      recv_stall_pct = 0;
      random_samples(250);
   endtask

   task automatic test_receiver_stalls();
      send_idle_pct  = 0;
      recv_stall_pct = 85;
      random_samples(250);
   endtask

   task automatic test_light_idling();
      send_idle_pct  = 9;
      recv_stall_pct = 9;
      random_samples(400);
   endtask

   // sender holds off until all responses are back, then resumes
   task automatic test_drain_pause();
      send_idle_pct  = 9;
      recv_stall_pct = 85;
      random_samples(150);
      wait_drained();
      random_samples(150);
   endtask

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
   end

   // response check against the oldest prediction
   always @(posedge clock) begin
      average_result_type got;
      average_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.channel = rsp_tdata[CHANNEL_W-1:0];
         got.average = rsp_tdata[CHANNEL_W +: SAMPLE_W];
         if (pending_averages.size() == 0) begin
            $error("unexpected response: out_channel %0d, average %0d",
                   got.channel, got.average);
            fail_count++;
         end else begin
            want = pending_averages.pop_front();
            if (got.channel !== want.channel) begin
               $error("out_channel mismatch: expected %0d, actual %0d",
                      want.channel, got.channel);
               fail_count++;
            end
            if (got.average !== want.average) begin
               $error("average mismatch: expected %0d, actual %0d",
                      want.average, got.average);
               fail_count++;
            end
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == STALL_LIMIT) begin
         $display("FAIL multichannel_moving_average_unit");
         $finish;
      end
   end

   // test sequence
   initial begin
      reset          <= 1'b1;
      req_tvalid     <= 1'b0;
      req_tdata      <= '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      for (int c = 0; c < CHANNELS; c++) begin
         channel_sum[c]  = '0;
         channel_fill[c] = '0;
         channel_slot[c] = '0;
      end
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_back_to_back();
      test_sender_gaps();
      test_receiver_stalls();
      test_drain_pause();
      test_light_idling();

      // let trailing responses land, then a margin for strays
      wait_drained();
      repeat (SETTLE) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS multichannel_moving_average_unit");
      end else begin
         $display("FAIL multichannel_moving_average_unit");
      end
      $finish;
   end

endmodule
